// ----- rtl/tlr_pkg.sv -----
// Shared types and constants for the thick line rasterizer.
package tlr_pkg;

    localparam int PIX_W = 13;
    localparam int BW_W = 7;
    localparam int HALF_W = 6;
    localparam int SQ_W = 7;

    localparam logic [BW_W-1:0] BRUSH_RESET = 7'd2;

    localparam logic ACT_LOAD = 1'b0;
    localparam logic ACT_ADV = 1'b1;

    typedef struct packed {
        logic [PIX_W-1:0] pixel_x;
        logic [PIX_W-1:0] pixel_y;
        logic             last;
    } result_t;

    localparam int RES_W = $bits(result_t);

endpackage

// ----- rtl/thick_line_rasterizer_unit.sv -----
// Top level of the thick line rasterizer with a square brush.
// A load transaction stores a segment; each advance transaction returns the
// next brush pixel, with last set on the final one, or nothing when the
// segment is done. Commands wait in a two-entry queue and results in a
// two-entry queue, so the input side keeps taking transactions while a result
// waits to be popped. Items are handled one at a time by a sequencer that
// takes one settle step per cycle: a load sets up its x pass and starts the
// serial divider, which computes the slope quotient one bit per cycle, and
// divides again for the y pass when its x pass is empty; an advance settles
// onto the next pixel, moving on to the next centre where needed, and runs
// the divider again when it crosses from the x pass into the y pass.
module thick_line_rasterizer_unit #(
    parameter int COORD_BITS = 12
) (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        push,
    output logic                        full,
    input  logic                        action,
    input  logic [COORD_BITS-1:0]       x_a,
    input  logic [COORD_BITS-1:0]       y_a,
    input  logic [COORD_BITS-1:0]       x_b,
    input  logic [COORD_BITS-1:0]       y_b,
    input  logic                        cfg_wr_en,
    input  logic [tlr_pkg::BW_W-1:0]    cfg_wr_data,
    output logic                        empty,
    input  logic                        pop,
    output logic [tlr_pkg::PIX_W-1:0]   pixel_x,
    output logic [tlr_pkg::PIX_W-1:0]   pixel_y,
    output logic                        last
);

    import tlr_pkg::*;

    logic                   cmd_empty;
    logic                   cmd_pop;
    logic [4*COORD_BITS:0]  cmd_data;
    logic                   res_full;
    logic                   res_push;
    result_t                res_data;
    logic [RES_W-1:0]       res_out_bits;
    result_t                res_out;

    tlr_front #(
        .COORD_BITS (COORD_BITS)
    ) u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (push),
        .full      (full),
        .action    (action),
        .x_a       (x_a),
        .y_a       (y_a),
        .x_b       (x_b),
        .y_b       (y_b),
        .cmd_empty (cmd_empty),
        .cmd_pop   (cmd_pop),
        .cmd_data  (cmd_data)
    );

    tlr_back #(
        .COORD_BITS (COORD_BITS)
    ) u_back (
        .clk         (clk),
        .rst_n       (rst_n),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_wr_data (cfg_wr_data),
        .cmd_empty   (cmd_empty),
        .cmd_pop     (cmd_pop),
        .cmd_data    (cmd_data),
        .res_full    (res_full),
        .res_push    (res_push),
        .res_data    (res_data)
    );

    tlr_fifo #(
        .WIDTH (RES_W),
        .DEPTH (2)
    ) u_res_queue (
        .clk   (clk),
        .rst_n (rst_n),
        .push  (res_push),
        .full  (res_full),
        .din   (res_data),
        .pop   (pop),
        .empty (empty),
        .dout  (res_out_bits)
    );

    assign res_out = res_out_bits;
    assign pixel_x = res_out.pixel_x;
    assign pixel_y = res_out.pixel_y;
    assign last = res_out.last;

endmodule

// ----- rtl/tlr_fifo.sv -----
// Small register-based queue, used for commands and for results.
module tlr_fifo #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 2
) (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             push,
    output logic             full,
    input  logic [WIDTH-1:0] din,
    input  logic             pop,
    output logic             empty,
    output logic [WIDTH-1:0] dout
);

    localparam int PTR_W = $clog2(DEPTH);
    localparam int CNT_W = $clog2(DEPTH + 1);

    logic [WIDTH-1:0] slot_reg [DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg, wr_ptr_next;
    logic [PTR_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [CNT_W-1:0] count_reg, count_next;
    logic             do_push;
    logic             do_pop;

    assign full = (count_reg == CNT_W'(DEPTH));
    assign empty = (count_reg == '0);
    assign dout = slot_reg[rd_ptr_reg];
    assign do_push = push && !full;
    assign do_pop = pop && !empty;

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next = count_reg;
        if (do_push)
        begin
            wr_ptr_next = (wr_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (do_pop)
        begin
            rd_ptr_next = (rd_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
        end
        case ({do_push, do_pop})
            2'b10: count_next = count_reg + 1'b1;
            2'b01: count_next = count_reg - 1'b1;
            default: count_next = count_reg;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            slot_reg[wr_ptr_reg] <= din;
        end
    end

endmodule

// ----- rtl/tlr_front.sv -----
// Front end: accepts input transactions, classifies them and queues commands.
module tlr_front #(
    parameter int COORD_BITS = 12
) (
    input  logic                    clk,
    input  logic                    rst_n,
    input  logic                    push,
    output logic                    full,
    input  logic                    action,
    input  logic [COORD_BITS-1:0]   x_a,
    input  logic [COORD_BITS-1:0]   y_a,
    input  logic [COORD_BITS-1:0]   x_b,
    input  logic [COORD_BITS-1:0]   y_b,
    output logic                    cmd_empty,
    input  logic                    cmd_pop,
    output logic [4*COORD_BITS:0]   cmd_data
);

    import tlr_pkg::*;

    logic [4*COORD_BITS:0] cmd_in;

    // Advance commands carry no coordinates.
    always_comb
    begin
        if (action == ACT_LOAD)
        begin
            cmd_in = {ACT_LOAD, x_a, y_a, x_b, y_b};
        end
        else
        begin
            cmd_in = {ACT_ADV, {(4 * COORD_BITS){1'b0}}};
        end
    end

    tlr_fifo #(
        .WIDTH (4 * COORD_BITS + 1),
        .DEPTH (2)
    ) u_cmd_queue (
        .clk   (clk),
        .rst_n (rst_n),
        .push  (push),
        .full  (full),
        .din   (cmd_in),
        .pop   (cmd_pop),
        .empty (cmd_empty),
        .dout  (cmd_data)
    );

endmodule

// ----- rtl/tlr_div.sv -----
// Restoring divider, one quotient bit per cycle.
module tlr_div #(
    parameter int WIDTH = 12
) (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             start,
    input  logic [WIDTH-1:0] dividend,
    input  logic [WIDTH-1:0] divisor,
    output logic             busy,
    output logic [WIDTH-1:0] quotient,
    output logic [WIDTH-1:0] remainder
);

    localparam int CNT_W = $clog2(WIDTH + 1);

    logic [WIDTH-1:0] rem_reg, rem_next;
    logic [WIDTH-1:0] quo_reg, quo_next;
    logic [CNT_W-1:0] step_reg, step_next;
    logic [WIDTH:0]   shifted;
    logic [WIDTH:0]   diff;
    logic             fits;

    assign shifted = {rem_reg, quo_reg[WIDTH-1]};
    assign diff = shifted - {1'b0, divisor};
    assign fits = (shifted >= {1'b0, divisor});
    assign busy = (step_reg != '0);
    assign quotient = quo_reg;
    assign remainder = rem_reg;

    always_comb
    begin
        rem_next = rem_reg;
        quo_next = quo_reg;
        step_next = step_reg;
        if (start)
        begin
            rem_next = '0;
            quo_next = dividend;
            step_next = CNT_W'(WIDTH);
        end
        else if (busy)
        begin
            rem_next = fits ? diff[WIDTH-1:0] : shifted[WIDTH-1:0];
            quo_next = {quo_reg[WIDTH-2:0], fits};
            step_next = step_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            step_reg <= '0;
        end
        else
        begin
            step_reg <= step_next;
        end
    end

    always_ff @(posedge clk)
    begin
        rem_reg <= rem_next;
        quo_reg <= quo_next;
    end

endmodule

// ----- rtl/tlr_back.sv -----
// Back end: segment state, centre stepping and brush square sequencing.
module tlr_back #(
    parameter int COORD_BITS = 12
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          cfg_wr_en,
    input  logic [tlr_pkg::BW_W-1:0]      cfg_wr_data,
    input  logic                          cmd_empty,
    output logic                          cmd_pop,
    input  logic [4*COORD_BITS:0]         cmd_data,
    input  logic                          res_full,
    output logic                          res_push,
    output tlr_pkg::result_t              res_data
);

    import tlr_pkg::*;

    localparam int CW = COORD_BITS;
    localparam int EXT_W = ((CW > HALF_W) ? CW : HALF_W) + 1;

    localparam int ST_W = 3;
    localparam logic [ST_W-1:0] S_IDLE = 3'd0;
    localparam logic [ST_W-1:0] S_SETUP = 3'd1;
    localparam logic [ST_W-1:0] S_DIV = 3'd2;
    localparam logic [ST_W-1:0] S_SETTLE = 3'd3;
    localparam logic [ST_W-1:0] S_EMIT = 3'd4;
    localparam logic [ST_W-1:0] S_PUSH = 3'd5;

    localparam logic [1:0] M_LOAD = 2'd0;
    localparam logic [1:0] M_PRE = 2'd1;
    localparam logic [1:0] M_POST = 2'd2;

    localparam logic PASS_X = 1'b0;
    localparam logic PASS_Y = 1'b1;

    logic [ST_W-1:0]   state_reg, state_next;
    logic [1:0]        mode_reg, mode_next;
    logic [BW_W-1:0]   brush_reg;
    logic [CW-1:0]     xa_reg, xa_next, ya_reg, ya_next;
    logic [CW-1:0]     xb_reg, xb_next, yb_reg, yb_next;
    logic              pass_reg, pass_next;
    logic [CW-1:0]     idx_reg, idx_next;
    logic [CW-1:0]     cnt_reg, cnt_next;
    logic [SQ_W-1:0]   col_reg, col_next;
    logic [SQ_W-1:0]   row_reg, row_next;
    logic              active_reg, active_next;
    logic [CW-1:0]     maj_reg, maj_next;
    logic [CW-1:0]     min_reg, min_next;
    logic [CW-1:0]     racc_reg, racc_next;
    logic              neg_reg, neg_next;
    logic [PIX_W-1:0]  px_reg, px_next;
    logic [PIX_W-1:0]  py_reg, py_next;

    logic              cmd_action;
    logic [CW-1:0]     cmd_xa, cmd_ya, cmd_xb, cmd_yb;

    logic              b_first;
    logic [CW-1:0]     pa, sa, pb, sb, p0, p1, s0, s1;
    logic [CW-1:0]     span;
    logic              s_neg;
    logic [CW-1:0]     s_mag;

    logic              div_start;
    logic              div_busy;
    logic [CW-1:0]     div_quo;
    logic [CW-1:0]     div_rem;

    logic [HALF_W-1:0] half;
    logic [CW-1:0]     cx, cy;
    logic [EXT_W-1:0]  cx_e, cy_e, half_e;
    logic              cx_ge, cy_ge;
    logic [EXT_W-1:0]  sum_x, sum_y;
    logic [EXT_W-1:0]  left_e, top_e;
    logic [SQ_W-1:0]   ncol, nrow;
    logic              row_wrap;
    logic [SQ_W-1:0]   col_step, row_step;
    logic              col_done;

    logic [CW:0]       racc_sum, racc_diff;
    logic              rwrap;
    logic [CW-1:0]     racc_adv;
    logic [CW-1:0]     inc;
    logic [CW-1:0]     min_adv;

    logic [EXT_W-1:0]        px_e, py_e;
    logic [EXT_W+PIX_W-1:0]  px_wide, py_wide;
    logic                    settled;

    assign cmd_action = cmd_data[4*CW];
    assign cmd_xa = cmd_data[4*CW-1:3*CW];
    assign cmd_ya = cmd_data[3*CW-1:2*CW];
    assign cmd_xb = cmd_data[2*CW-1:CW];
    assign cmd_yb = cmd_data[CW-1:0];

    // Endpoint ordering along the major axis of the current pass.
    always_comb
    begin
        if (pass_reg == PASS_Y)
        begin
            b_first = !(ya_reg < yb_reg);
            pa = ya_reg;
            sa = xa_reg;
            pb = yb_reg;
            sb = xb_reg;
        end
        else
        begin
            b_first = !(xa_reg < xb_reg);
            pa = xa_reg;
            sa = ya_reg;
            pb = xb_reg;
            sb = yb_reg;
        end
        p0 = b_first ? pb : pa;
        s0 = b_first ? sb : sa;
        p1 = b_first ? pa : pb;
        s1 = b_first ? sa : sb;
        span = p1 - p0;
        s_neg = (s1 < s0);
        s_mag = s_neg ? s0 - s1 : s1 - s0;
    end

    tlr_div #(
        .WIDTH (CW)
    ) u_div (
        .clk       (clk),
        .rst_n     (rst_n),
        .start     (div_start),
        .dividend  (s_mag),
        .divisor   (span),
        .busy      (div_busy),
        .quotient  (div_quo),
        .remainder (div_rem)
    );

    // Square geometry around the current centre.
    assign half = brush_reg[BW_W-1:1];
    assign cx = (pass_reg == PASS_Y) ? min_reg : maj_reg;
    assign cy = (pass_reg == PASS_Y) ? maj_reg : min_reg;
    assign cx_e = EXT_W'(cx);
    assign cy_e = EXT_W'(cy);
    assign half_e = EXT_W'(half);
    assign cx_ge = (cx_e >= half_e);
    assign cy_ge = (cy_e >= half_e);
    assign sum_x = cx_e + half_e;
    assign sum_y = cy_e + half_e;
    assign ncol = cx_ge ? {half, 1'b0} : sum_x[SQ_W-1:0];
    assign nrow = cy_ge ? {half, 1'b0} : sum_y[SQ_W-1:0];
    assign left_e = cx_ge ? cx_e - half_e : '0;
    assign top_e = cy_ge ? cy_e - half_e : '0;
    assign row_wrap = (row_reg >= nrow);
    assign col_step = row_wrap ? col_reg + 1'b1 : col_reg;
    assign row_step = row_wrap ? '0 : row_reg;
    assign col_done = (col_step >= ncol);

    // Incremental quotient: the minor coordinate moves by quotient plus a carry
    // from the running remainder.
    assign racc_sum = {1'b0, racc_reg} + {1'b0, div_rem};
    assign racc_diff = racc_sum - {1'b0, cnt_reg};
    assign rwrap = (racc_sum >= {1'b0, cnt_reg});
    assign racc_adv = rwrap ? racc_diff[CW-1:0] : racc_sum[CW-1:0];
    assign inc = div_quo + {{(CW - 1){1'b0}}, rwrap};
    assign min_adv = neg_reg ? min_reg - inc : min_reg + inc;

    assign px_e = left_e + EXT_W'(col_reg);
    assign py_e = top_e + EXT_W'(row_reg);
    assign px_wide = {{PIX_W{1'b0}}, px_e};
    assign py_wide = {{PIX_W{1'b0}}, py_e};

    assign res_data.pixel_x = px_reg;
    assign res_data.pixel_y = py_reg;
    assign res_data.last = !active_reg;

    always_comb
    begin
        state_next = state_reg;
        mode_next = mode_reg;
        xa_next = xa_reg;
        ya_next = ya_reg;
        xb_next = xb_reg;
        yb_next = yb_reg;
        pass_next = pass_reg;
        idx_next = idx_reg;
        cnt_next = cnt_reg;
        col_next = col_reg;
        row_next = row_reg;
        active_next = active_reg;
        maj_next = maj_reg;
        min_next = min_reg;
        racc_next = racc_reg;
        neg_next = neg_reg;
        px_next = px_reg;
        py_next = py_reg;
        cmd_pop = 1'b0;
        res_push = 1'b0;
        div_start = 1'b0;
        settled = 1'b0;

        unique case (state_reg)
            S_IDLE:
            begin
                if (!cmd_empty && (cmd_action == ACT_LOAD || !res_full))
                begin
                    cmd_pop = 1'b1;
                    if (cmd_action == ACT_LOAD)
                    begin
                        xa_next = cmd_xa;
                        ya_next = cmd_ya;
                        xb_next = cmd_xb;
                        yb_next = cmd_yb;
                        pass_next = PASS_X;
                        idx_next = '0;
                        col_next = '0;
                        row_next = '0;
                        active_next = 1'b1;
                        mode_next = M_LOAD;
                        state_next = S_SETUP;
                    end
                    else
                    begin
                        mode_next = M_PRE;
                        state_next = S_SETTLE;
                    end
                end
            end
            S_SETUP:
            begin
                maj_next = p0;
                min_next = s0;
                cnt_next = span;
                neg_next = s_neg;
                racc_next = '0;
                div_start = 1'b1;
                state_next = S_DIV;
            end
            S_DIV:
            begin
                if (!div_busy)
                begin
                    state_next = S_SETTLE;
                end
            end
            S_SETTLE:
            begin
                if (!active_reg)
                begin
                    settled = 1'b1;
                end
                else if (idx_reg >= cnt_reg)
                begin
                    if (pass_reg == PASS_X)
                    begin
                        pass_next = PASS_Y;
                        idx_next = '0;
                        col_next = '0;
                        row_next = '0;
                        state_next = S_SETUP;
                    end
                    else
                    begin
                        active_next = 1'b0;
                        settled = 1'b1;
                    end
                end
                else if (half == '0)
                begin
                    active_next = 1'b0;
                    settled = 1'b1;
                end
                else if (col_done)
                begin
                    col_next = '0;
                    row_next = '0;
                    idx_next = idx_reg + 1'b1;
                    maj_next = maj_reg + 1'b1;
                    min_next = min_adv;
                    racc_next = racc_adv;
                end
                else
                begin
                    col_next = col_step;
                    row_next = row_step;
                    settled = 1'b1;
                end
                if (settled)
                begin
                    case (mode_reg)
                        M_PRE: state_next = active_next ? S_EMIT : S_IDLE;
                        M_POST: state_next = S_PUSH;
                        default: state_next = S_IDLE;
                    endcase
                end
            end
            S_EMIT:
            begin
                px_next = px_wide[PIX_W-1:0];
                py_next = py_wide[PIX_W-1:0];
                row_next = row_reg + 1'b1;
                mode_next = M_POST;
                state_next = S_SETTLE;
            end
            S_PUSH:
            begin
                res_push = 1'b1;
                state_next = S_IDLE;
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            mode_reg <= M_LOAD;
            brush_reg <= BRUSH_RESET;
            xa_reg <= '0;
            ya_reg <= '0;
            xb_reg <= '0;
            yb_reg <= '0;
            pass_reg <= PASS_X;
            idx_reg <= '0;
            cnt_reg <= '0;
            col_reg <= '0;
            row_reg <= '0;
            active_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            mode_reg <= mode_next;
            if (cfg_wr_en)
            begin
                brush_reg <= cfg_wr_data;
            end
            xa_reg <= xa_next;
            ya_reg <= ya_next;
            xb_reg <= xb_next;
            yb_reg <= yb_next;
            pass_reg <= pass_next;
            idx_reg <= idx_next;
            cnt_reg <= cnt_next;
            col_reg <= col_next;
            row_reg <= row_next;
            active_reg <= active_next;
        end
    end

    always_ff @(posedge clk)
    begin
        maj_reg <= maj_next;
        min_reg <= min_next;
        racc_reg <= racc_next;
        neg_reg <= neg_next;
        px_reg <= px_next;
        py_reg <= py_next;
    end

    a_adv_room: assert property (@(posedge clk) disable iff (!rst_n)
        cmd_pop && cmd_action == ACT_ADV |-> !res_full)
        else $error("advance taken without room for its result");

    a_div_idle: assert property (@(posedge clk) disable iff (!rst_n)
        div_start |-> !div_busy)
        else $error("divider restarted while busy");

    a_settle_div: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == S_SETTLE |-> !div_busy)
        else $error("centre stepping before the divider finished");

    a_emit_valid: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == S_EMIT |-> active_reg && idx_reg < cnt_reg && half != '0)
        else $error("pixel emitted outside a valid square");

    a_idx_bound: assert property (@(posedge clk) disable iff (!rst_n)
        active_reg && state_reg == S_SETTLE |-> idx_reg <= cnt_reg)
        else $error("sample index ran past the pass length");

endmodule

// ----- tb/thick_line_rasterizer_checker.sv -----
// Checker for the thick line rasterizer: predicts brush pixels and compares them.
module thick_line_rasterizer_checker #(
    parameter int COORD_BITS = 12
) (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        push,
    input  logic                        full,
    input  logic                        action,
    input  logic [COORD_BITS-1:0]       x_a,
    input  logic [COORD_BITS-1:0]       y_a,
    input  logic [COORD_BITS-1:0]       x_b,
    input  logic [COORD_BITS-1:0]       y_b,
    input  logic                        cfg_wr_en,
    input  logic [tlr_pkg::BW_W-1:0]    cfg_wr_data,
    input  logic                        empty,
    input  logic                        pop,
    input  logic [tlr_pkg::PIX_W-1:0]   pixel_x,
    input  logic [tlr_pkg::PIX_W-1:0]   pixel_y,
    input  logic                        last,
    output int                          errors,
    output int                          outstanding
);

    timeunit 1ns;
    timeprecision 1ps;

    logic [COORD_BITS-1:0]    seg_end [4];
    logic [tlr_pkg::BW_W-1:0] brush = tlr_pkg::BRUSH_RESET;
    bit                       y_pass;
    longint                   centre_idx;
    longint                   sq_col;
    longint                   sq_row;
    bit                       drawing;
    int                       mismatch_count;

    tlr_pkg::result_t         expected_pixels [$];

    function automatic longint centre_count(input bit along_y);
        longint d;
        if (!along_y)
            d = longint'(seg_end[2]) - longint'(seg_end[0]);
        else
            d = longint'(seg_end[3]) - longint'(seg_end[1]);
        return (d < 0) ? -d : d;
    endfunction

    function automatic void centre_of(input bit along_y, input longint idx,
                                      output longint cx, output longint cy);
        longint xa, ya, xb, yb, x0, y0, x1, y1;
        xa = longint'(seg_end[0]);
        ya = longint'(seg_end[1]);
        xb = longint'(seg_end[2]);
        yb = longint'(seg_end[3]);
        if ((!along_y && xa < xb) || (along_y && ya < yb))
        begin
            x0 = xa; y0 = ya; x1 = xb; y1 = yb;
        end
        else
        begin
            x0 = xb; y0 = yb; x1 = xa; y1 = ya;
        end
        cx = x0;
        cy = y0;
        if (!along_y && x1 != x0)
        begin
            cx = x0 + idx;
            cy = y0 + (idx * (y1 - y0)) / (x1 - x0);
        end
        else if (along_y && y1 != y0)
        begin
            cy = y0 + idx;
            cx = x0 + ((x1 - x0) * idx) / (y1 - y0);
        end
    endfunction

    // Walks the position forward until it names a pixel inside the current
    // square, or the segment runs out or the brush is too narrow to draw.
    function automatic void seek_next_pixel();
        longint half, cx, cy, col0, row0, ncol, nrow;
        while (drawing)
        begin
            half = longint'(brush >> 1);
            if (centre_idx >= centre_count(y_pass))
            begin
                if (!y_pass)
                begin
                    y_pass = 1'b1;
                    centre_idx = 0;
                    sq_col = 0;
                    sq_row = 0;
                    continue;
                end
                drawing = 1'b0;
                break;
            end
            if (half == 0)
            begin
                drawing = 1'b0;
                break;
            end
            centre_of(y_pass, centre_idx, cx, cy);
            col0 = (cx - half < 0) ? 0 : cx - half;
            row0 = (cy - half < 0) ? 0 : cy - half;
            ncol = cx + half - col0;
            nrow = cy + half - row0;
            if (sq_row >= nrow)
            begin
                sq_row = 0;
                sq_col++;
            end
            if (sq_col >= ncol)
            begin
                sq_col = 0;
                sq_row = 0;
                centre_idx++;
                continue;
            end
            break;
        end
    endfunction

    function automatic bit next_brush_pixel(input logic act,
                                            input logic [COORD_BITS-1:0] xa,
                                            input logic [COORD_BITS-1:0] ya,
                                            input logic [COORD_BITS-1:0] xb,
                                            input logic [COORD_BITS-1:0] yb,
                                            output tlr_pkg::result_t pix);
        longint half, cx, cy, col0, row0, px, py;
        pix = '0;
        if (act == tlr_pkg::ACT_LOAD)
        begin
            seg_end[0] = xa;
            seg_end[1] = ya;
            seg_end[2] = xb;
            seg_end[3] = yb;
            y_pass = 1'b0;
            centre_idx = 0;
            sq_col = 0;
            sq_row = 0;
            drawing = 1'b1;
            seek_next_pixel();
            return 1'b0;
        end
        seek_next_pixel();
        if (!drawing)
            return 1'b0;
        half = longint'(brush >> 1);
        centre_of(y_pass, centre_idx, cx, cy);
        col0 = (cx - half < 0) ? 0 : cx - half;
        row0 = (cy - half < 0) ? 0 : cy - half;
        px = col0 + sq_col;
        py = row0 + sq_row;
        sq_row++;
        seek_next_pixel();
        pix.pixel_x = px[tlr_pkg::PIX_W-1:0];
        pix.pixel_y = py[tlr_pkg::PIX_W-1:0];
        pix.last = !drawing;
        return 1'b1;
    endfunction

    always @(posedge clk or negedge rst_n)
    begin
        tlr_pkg::result_t want;
        tlr_pkg::result_t pix;
        if (!rst_n)
        begin
            brush = tlr_pkg::BRUSH_RESET;
            foreach (seg_end[i])
                seg_end[i] = '0;
            y_pass = 1'b0;
            centre_idx = 0;
            sq_col = 0;
            sq_row = 0;
            drawing = 1'b0;
            expected_pixels.delete();
        end
        else
        begin
            if (cfg_wr_en)
                brush = cfg_wr_data;
            if (pop && !empty)
            begin
                if (expected_pixels.size() == 0)
                begin
                    mismatch_count++;
                    if (mismatch_count <= 10)
                        $display("unexpected pixel transaction: x=%0d y=%0d last=%0d",
                                 pixel_x, pixel_y, last);
                end
                else
                begin
                    want = expected_pixels.pop_front();
                    if (pixel_x !== want.pixel_x || pixel_y !== want.pixel_y
                        || last !== want.last)
                    begin
                        mismatch_count++;
                        if (mismatch_count <= 10)
                            $display("expected x/y/last %0d/%0d/%0d, got %0d/%0d/%0d",
                                     want.pixel_x, want.pixel_y, want.last,
                                     pixel_x, pixel_y, last);
                    end
                end
            end
            if (push && !full)
            begin
                if (next_brush_pixel(action, x_a, y_a, x_b, y_b, pix))
                    expected_pixels.insert(expected_pixels.size(), pix);
            end
        end
        outstanding <= expected_pixels.size();
        errors <= mismatch_count;
    end

endmodule

// ----- tb/thick_line_rasterizer_unit_test.sv -----
// Testbench top for the thick line rasterizer: stimulus, idling and final verdict.
module thick_line_rasterizer_unit_test;

    timeunit 1ns;
    timeprecision 1ps;

    localparam int COORD_MAX = 4095;
    localparam int QUIET_CYCLES = 200;
    localparam int CYCLE_LIMIT = 600000;
    localparam int PHASES = 10;
    localparam int BRUSH_PLAN [PHASES] = '{1, 64, 5, 0, 2, 6, 3, 4, 9, 2};

    logic                       clk = 1'b0;
    logic                       rst_n;
    logic                       push;
    logic                       full;
    logic                       action;
    logic [11:0]                x_a;
    logic [11:0]                y_a;
    logic [11:0]                x_b;
    logic [11:0]                y_b;
    logic                       cfg_wr_en;
    logic [tlr_pkg::BW_W-1:0]   cfg_wr_data;
    logic                       empty;
    logic                       pop;
    logic [tlr_pkg::PIX_W-1:0]  pixel_x;
    logic [tlr_pkg::PIX_W-1:0]  pixel_y;
    logic                       last;

    int errors;
    int outstanding;
    int send_idle_pct;
    int recv_stall_pct;
    int items_sent;
    int cycle_count;

    thick_line_rasterizer_unit #(
        .COORD_BITS(12)
    ) DUT (
        .clk(clk),
        .rst_n(rst_n),
        .push(push),
        .full(full),
        .action(action),
        .x_a(x_a),
        .y_a(y_a),
        .x_b(x_b),
        .y_b(y_b),
        .cfg_wr_en(cfg_wr_en),
        .cfg_wr_data(cfg_wr_data),
        .empty(empty),
        .pop(pop),
        .pixel_x(pixel_x),
        .pixel_y(pixel_y),
        .last(last)
    );

    thick_line_rasterizer_checker #(
        .COORD_BITS(12)
    ) pixel_checker (
        .clk(clk),
        .rst_n(rst_n),
        .push(push),
        .full(full),
        .action(action),
        .x_a(x_a),
        .y_a(y_a),
        .x_b(x_b),
        .y_b(y_b),
        .cfg_wr_en(cfg_wr_en),
        .cfg_wr_data(cfg_wr_data),
        .empty(empty),
        .pop(pop),
        .pixel_x(pixel_x),
        .pixel_y(pixel_y),
        .last(last),
        .errors(errors),
        .outstanding(outstanding)
    );

    always
    begin
        #4 clk = 1'b1;
        #4 clk = 1'b0;
    end

    always @(posedge clk)
    begin
        if (!rst_n)
            pop <= 1'b0;
        else
            pop <= ($urandom_range(0, 99) >= recv_stall_pct);
    end

    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT)
        begin
            $display("[thick_line_rasterizer_unit] ERROR");
            $finish;
        end
    end

    task automatic send_item(input logic act, input logic [11:0] xa, input logic [11:0] ya,
                             input logic [11:0] xb, input logic [11:0] yb);
        while ($urandom_range(0, 99) < send_idle_pct)
        begin
            push <= 1'b0;
            @(posedge clk);
        end
        push <= 1'b1;
        action <= act;
        x_a <= xa;
        y_a <= ya;
        x_b <= xb;
        y_b <= yb;
        @(posedge clk);
        while (full)
            @(posedge clk);
        items_sent++;
    endtask

    task automatic send_advance();
        send_item(tlr_pkg::ACT_ADV,
                  12'($urandom_range(0, COORD_MAX)), 12'($urandom_range(0, COORD_MAX)),
                  12'($urandom_range(0, COORD_MAX)), 12'($urandom_range(0, COORD_MAX)));
    endtask

    task automatic hold_until_drained();
        push <= 1'b0;
        @(posedge clk);
        while (outstanding != 0)
            @(posedge clk);
    endtask

    task automatic wait_until_quiet();
        hold_until_drained();
        repeat (QUIET_CYCLES) @(posedge clk);
    endtask

    task automatic set_brush(input int w);
        cfg_wr_en <= 1'b1;
        cfg_wr_data <= w[tlr_pkg::BW_W-1:0];
        @(posedge clk);
        cfg_wr_en <= 1'b0;
    endtask

    function automatic logic [11:0] pick_coord();
        case ($urandom_range(0, 5))
            0: return 12'($urandom_range(0, 3));
            1: return 12'($urandom_range(COORD_MAX - 3, COORD_MAX));
            default: return 12'($urandom_range(0, COORD_MAX));
        endcase
    endfunction

    function automatic logic [11:0] nudge(input logic [11:0] c, input int spread);
        int v;
        v = int'(c) + int'($urandom_range(0, 2 * spread)) - spread;
        if (v < 0)
            v = 0;
        if (v > COORD_MAX)
            v = COORD_MAX;
        return v[11:0];
    endfunction

    function automatic int pixel_estimate(input logic [11:0] xa, input logic [11:0] ya,
                                          input logic [11:0] xb, input logic [11:0] yb,
                                          input int w);
        int dx, dy, side;
        dx = int'(xa) - int'(xb);
        dy = int'(ya) - int'(yb);
        side = (w / 2) * 2;
        return ((dx < 0 ? -dx : dx) + (dy < 0 ? -dy : dy)) * side * side;
    endfunction

    task automatic run_segment(input int w);
        logic [11:0] xa, ya, xb, yb;
        int spread, n;
        if ($urandom_range(0, 9) == 0)
        begin
            send_item(1'($urandom_range(0, 1)), 12'($urandom_range(0, COORD_MAX)),
                      12'($urandom_range(0, COORD_MAX)), 12'($urandom_range(0, COORD_MAX)),
                      12'($urandom_range(0, COORD_MAX)));
            return;
        end
        spread = (w >= 32) ? 2 : 8;
        xa = pick_coord();
        ya = pick_coord();
        xb = nudge(xa, spread);
        yb = nudge(ya, spread);
        send_item(tlr_pkg::ACT_LOAD, xa, ya, xb, yb);
        n = pixel_estimate(xa, ya, xb, yb, w);
        if ($urandom_range(0, 5) == 0)
            n = $urandom_range(0, n);
        if (n > 120)
            n = 120;
        n += $urandom_range(0, 2);
        repeat (n) send_advance();
    endtask

    initial
    begin
        int w, goal;
        rst_n = 1'b0;
        push = 1'b0;
        action = tlr_pkg::ACT_LOAD;
        x_a = '0;
        y_a = '0;
        x_b = '0;
        y_b = '0;
        cfg_wr_en = 1'b0;
        cfg_wr_data = '0;
        send_idle_pct = 9;
        recv_stall_pct = 51;
        items_sent = 0;
        repeat (2) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed part at the reset brush width: idle advance, degenerate
        // segment, coordinate extremes, clipping at zero, negative slope.
        send_advance();
        send_item(tlr_pkg::ACT_LOAD, 12'd0, 12'd0, 12'd0, 12'd0);
        send_advance();
        send_item(tlr_pkg::ACT_LOAD, 12'd4095, 12'd0, 12'd0, 12'd4095);
        repeat (2) send_advance();
        send_item(tlr_pkg::ACT_LOAD, 12'd0, 12'd0, 12'd1, 12'd3);
        repeat (7) send_advance();
        send_item(tlr_pkg::ACT_LOAD, 12'd4095, 12'd0, 12'd4092, 12'd2);
        repeat (6) send_advance();
        send_item(tlr_pkg::ACT_LOAD, 12'd2, 12'd4095, 12'd0, 12'd4094);
        repeat (2) send_advance();
        wait_until_quiet();

        for (int p = 0; p < PHASES; p++)
        begin
            w = BRUSH_PLAN[p];
            if (p < 4)
            begin
                send_idle_pct = 9;
                recv_stall_pct = 51;
            end
            else if (p < 7)
            begin
                send_idle_pct = 51;
                recv_stall_pct = 9;
            end
            else
            begin
                send_idle_pct = 0;
                recv_stall_pct = 0;
            end
            set_brush(w);
            // The segment left over from the previous phase goes on at the new width.
            repeat ($urandom_range(2, 6)) send_advance();
            goal = items_sent + ((w < 2) ? 60 : 160);
            while (items_sent < goal - 100)
                run_segment(w);
            if (p == 5)
                hold_until_drained();
            while (items_sent < goal)
                run_segment(w);
            send_item(tlr_pkg::ACT_LOAD, pick_coord(), pick_coord(), pick_coord(), pick_coord());
            repeat ($urandom_range(1, 4)) send_advance();
            wait_until_quiet();
        end

        if (errors == 0 && outstanding == 0)
            $display("[thick_line_rasterizer_unit] OK");
        else
            $display("[thick_line_rasterizer_unit] ERROR");
        $finish;
    end

endmodule

// ----- filelist.f -----
rtl/tlr_pkg.sv
rtl/tlr_fifo.sv
rtl/tlr_front.sv
rtl/tlr_div.sv
rtl/tlr_back.sv
rtl/thick_line_rasterizer_unit.sv
tb/thick_line_rasterizer_checker.sv
tb/thick_line_rasterizer_unit_test.sv
